@@ hw/rtl/prr_pkg.sv @@
// Package for the priority round-robin scheduler core.
// Holds default sizes, request, thread state and status codes, and shared types.
// No dependencies.
package prr_pkg;

    localparam int DEF_THREAD_SLOTS    = 64;
    localparam int DEF_PRIORITY_LEVELS = 8;

    localparam logic [2:0] REQ_CREATE  = 3'd0;
    localparam logic [2:0] REQ_UNBLOCK = 3'd1;
    localparam logic [2:0] REQ_BLOCK   = 3'd2;
    localparam logic [2:0] REQ_YIELD   = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;
    localparam logic [2:0] REQ_SETPRIO = 3'd5;
    localparam logic [2:0] REQ_REMOVE  = 3'd6;
    localparam logic [2:0] REQ_QUERY   = 3'd7;

    localparam logic [1:0] TS_FREE    = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_RUNNING = 2'd2;
    localparam logic [1:0] TS_WAITING = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_SLOT  = 2'd1;
    localparam logic [1:0] STAT_BAD_STATE = 2'd2;

    typedef struct packed {
        logic state;
        logic prio;
        logic ticks;
    } t_slot_we;

endpackage

@@ hw/rtl/prr_slot_mem.sv @@
// Per-slot memory: thread state, priority and CPU tick count.
// Field write enables, registered read; valid bits make unwritten slots read free.
// Depends on prr_pkg.
module prr_slot_mem import prr_pkg::*; #(
    parameter int THREAD_SLOTS = DEF_THREAD_SLOTS,
    localparam int SW = $clog2(THREAD_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [SW-1:0] i_rd_addr,
    output logic [1:0]    o_rd_state,
    output logic [2:0]    o_rd_prio,
    output logic [31:0]   o_rd_ticks,
    input  logic [SW-1:0] i_wr_addr,
    input  t_slot_we      i_we,
    input  logic [1:0]    i_wr_state,
    input  logic [2:0]    i_wr_prio,
    input  logic [31:0]   i_wr_ticks
);

    logic [1:0]  state_mem [THREAD_SLOTS];
    logic [2:0]  prio_mem  [THREAD_SLOTS];
    logic [31:0] ticks_mem [THREAD_SLOTS];
    logic [THREAD_SLOTS-1:0] r_vld;
    logic        r_vld_q;
    logic [1:0]  r_state_q;
    logic [2:0]  r_prio_q;
    logic [31:0] r_ticks_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_we.state) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_vld_q <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we.state) begin
            state_mem[i_wr_addr] <= i_wr_state;
        end
        if (i_we.prio) begin
            prio_mem[i_wr_addr] <= i_wr_prio;
        end
        if (i_we.ticks) begin
            ticks_mem[i_wr_addr] <= i_wr_ticks;
        end
        r_state_q <= state_mem[i_rd_addr];
        r_prio_q  <= prio_mem[i_rd_addr];
        r_ticks_q <= ticks_mem[i_rd_addr];
    end

    assign o_rd_state = r_vld_q ? r_state_q : TS_FREE;
    assign o_rd_prio  = r_prio_q;
    assign o_rd_ticks = r_ticks_q;

endmodule

@@ hw/rtl/prr_link_mem.sv @@
// Ready-queue link memory: next and prev slot for each thread slot.
// One shared read address with registered data, separate write ports.
// Depends on prr_pkg.
module prr_link_mem import prr_pkg::*; #(
    parameter int THREAD_SLOTS = DEF_THREAD_SLOTS,
    localparam int SW = $clog2(THREAD_SLOTS)
) (
    input  logic          i_clk,
    input  logic [SW-1:0] i_rd_addr,
    output logic [SW-1:0] o_rd_next,
    output logic [SW-1:0] o_rd_prev,
    input  logic          i_nx_we,
    input  logic [SW-1:0] i_nx_addr,
    input  logic [SW-1:0] i_nx_data,
    input  logic          i_pv_we,
    input  logic [SW-1:0] i_pv_addr,
    input  logic [SW-1:0] i_pv_data
);

    logic [SW-1:0] next_mem [THREAD_SLOTS];
    logic [SW-1:0] prev_mem [THREAD_SLOTS];
    logic [SW-1:0] r_next_q;
    logic [SW-1:0] r_prev_q;

    always_ff @(posedge i_clk) begin
        if (i_nx_we) begin
            next_mem[i_nx_addr] <= i_nx_data;
        end
        if (i_pv_we) begin
            prev_mem[i_pv_addr] <= i_pv_data;
        end
        r_next_q <= next_mem[i_rd_addr];
        r_prev_q <= prev_mem[i_rd_addr];
    end

    assign o_rd_next = r_next_q;
    assign o_rd_prev = r_prev_q;

endmodule

@@ hw/rtl/prr_level_table.sv @@
// Per-level queue heads and non-empty flags, plus highest non-empty level search.
// Depends on prr_pkg.
module prr_level_table import prr_pkg::*; #(
    parameter int THREAD_SLOTS    = DEF_THREAD_SLOTS,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
    localparam int SW = $clog2(THREAD_SLOTS),
    localparam int LW = $clog2(PRIORITY_LEVELS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [LW-1:0] i_lv,
    output logic [SW-1:0] o_head,
    output logic          o_nonempty,
    input  logic          i_head_we,
    input  logic [SW-1:0] i_head_data,
    input  logic          i_ne_we,
    input  logic          i_ne_data,
    output logic          o_any,
    output logic [LW-1:0] o_top_lv
);

    logic [SW-1:0]              r_head [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] r_ne;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne <= '0;
        end else if (i_ne_we) begin
            r_ne[i_lv] <= i_ne_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_head_we) begin
            r_head[i_lv] <= i_head_data;
        end
    end

    always_comb begin
        o_top_lv = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (r_ne[i]) begin
                o_top_lv = LW'(i);
            end
        end
    end

    assign o_any      = |r_ne;
    assign o_head     = r_head[i_lv];
    assign o_nonempty = r_ne[i_lv];

endmodule

@@ hw/rtl/priority_round_robin_scheduler_core.sv @@
// Priority round-robin scheduler core: sequencer over slot, link and level tables.
// Each request walks the states it needs (slot read, enqueue, dequeue, schedule pass),
// with dependent link memory reads between them; one word in flight at a time, so a
// new word is taken only after the last one has moved into the output register.
// A finished word waits in the output register while the next word is taken.
// Synchronous active-low reset: all slots free, all levels empty, idle thread runs.
module priority_round_robin_scheduler_core import prr_pkg::*; #(
    parameter int THREAD_SLOTS    = DEF_THREAD_SLOTS,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
    localparam int SW = $clog2(THREAD_SLOTS),
    localparam int LW = $clog2(PRIORITY_LEVELS)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [5:0]  i_thread_slot,
    input  logic [2:0]  i_priority_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_running_slot,
    output logic        o_running_idle,
    output logic        o_switched,
    output logic [1:0]  o_result_status,
    output logic [1:0]  o_query_state,
    output logic [2:0]  o_query_priority,
    output logic [31:0] o_query_cpu_time
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDS  = 4'd1;
    localparam logic [3:0] S_ENQ0 = 4'd2;
    localparam logic [3:0] S_ENQ1 = 4'd3;
    localparam logic [3:0] S_ENQ2 = 4'd4;
    localparam logic [3:0] S_DEQ0 = 4'd5;
    localparam logic [3:0] S_DEQ1 = 4'd6;
    localparam logic [3:0] S_SCH0 = 4'd7;
    localparam logic [3:0] S_SCH1 = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]    r_state;
    logic [2:0]    r_req;
    logic [2:0]    r_prio;
    logic          r_slot_ok;
    logic [SW-1:0] r_addr;
    logic [SW-1:0] r_cur;
    logic          r_idle;
    logic [SW-1:0] r_old_cur;
    logic          r_old_idle;
    logic [SW-1:0] r_t;
    logic [SW-1:0] r_tail;
    logic [LW-1:0] r_lv;
    logic [LW-1:0] r_new_lv;
    logic          r_do_enq;
    logic          r_do_sched;
    logic [1:0]    r_status;
    logic [1:0]    r_qs;
    logic [2:0]    r_qp;
    logic [31:0]   r_qc;
    logic          r_ov;
    logic [5:0]    r_o_slot;
    logic          r_o_idle;
    logic          r_o_sw;
    logic [1:0]    r_o_status;
    logic [1:0]    r_o_qs;
    logic [2:0]    r_o_qp;
    logic [31:0]   r_o_qc;

    logic            accept;
    logic            in_ok;
    logic [SW+5:0]   in_ext;
    logic [SW-1:0]   in_slot;
    logic [2:0]      in_prio;
    logic [SW-1:0]   rd_addr;
    logic [LW+2:0]   rd_pr_ext;
    logic [LW+2:0]   new_pr_ext;
    logic [LW-1:0]   rd_lv;
    logic [LW-1:0]   new_lv;
    logic [1:0]      st_eff;
    logic            run_ok;
    logic            need_sched;
    logic [SW+5:0]   cur_ext;
    logic            load_out;

    logic [1:0]    sm_state;
    logic [2:0]    sm_prio;
    logic [31:0]   sm_ticks;
    logic [SW-1:0] sm_wr_addr;
    t_slot_we      sm_we;
    logic [1:0]    sm_wr_state;
    logic [2:0]    sm_wr_prio;
    logic [31:0]   sm_wr_ticks;

    logic [SW-1:0] lk_rd_addr;
    logic [SW-1:0] lk_next;
    logic [SW-1:0] lk_prev;
    logic          lk_nx_we;
    logic [SW-1:0] lk_nx_addr;
    logic [SW-1:0] lk_nx_data;
    logic          lk_pv_we;
    logic [SW-1:0] lk_pv_addr;
    logic [SW-1:0] lk_pv_data;

    logic [SW-1:0] lv_head;
    logic          lv_ne;
    logic          lv_head_we;
    logic [SW-1:0] lv_head_data;
    logic          lv_ne_we;
    logic          lv_ne_data;
    logic          lv_any;
    logic [LW-1:0] lv_top;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_ok      = 32'(i_thread_slot) < THREAD_SLOTS;
    assign in_ext     = {{SW{1'b0}}, i_thread_slot};
    assign in_slot    = in_ok ? in_ext[SW-1:0] : '0;
    assign in_prio    = (32'(i_priority_req) >= PRIORITY_LEVELS) ?
                        3'(PRIORITY_LEVELS - 1) : i_priority_req;
    assign rd_addr    = (i_req_type == REQ_BLOCK || i_req_type == REQ_YIELD ||
                         i_req_type == REQ_TICK) ? r_cur : in_slot;

    assign rd_pr_ext  = {{LW{1'b0}}, sm_prio};
    assign new_pr_ext = {{LW{1'b0}}, r_prio};
    assign rd_lv      = rd_pr_ext[LW-1:0];
    assign new_lv     = new_pr_ext[LW-1:0];
    assign st_eff     = r_slot_ok ? sm_state : TS_FREE;
    assign run_ok     = !r_idle && (sm_state == TS_RUNNING);
    assign need_sched = !r_idle && (r_cur == r_addr);
    assign cur_ext    = {6'b0, r_cur};
    assign load_out   = (r_state == S_DONE) && (!r_ov || !i_out_stall);

    always_comb begin
        sm_wr_addr   = r_addr;
        sm_we        = '0;
        sm_wr_state  = TS_READY;
        sm_wr_prio   = r_prio;
        sm_wr_ticks  = sm_ticks + 32'd1;
        lk_rd_addr   = r_t;
        lk_nx_we     = 1'b0;
        lk_nx_addr   = r_t;
        lk_nx_data   = r_t;
        lk_pv_we     = 1'b0;
        lk_pv_addr   = r_t;
        lk_pv_data   = r_t;
        lv_head_we   = 1'b0;
        lv_head_data = r_t;
        lv_ne_we     = 1'b0;
        lv_ne_data   = 1'b1;
        unique case (r_state)
            S_RDS: begin
                unique case (r_req)
                    REQ_CREATE: begin
                        if (r_slot_ok && sm_state == TS_FREE) begin
                            sm_we       = '{state: 1'b1, prio: 1'b1, ticks: 1'b1};
                            sm_wr_ticks = '0;
                        end
                    end
                    REQ_UNBLOCK: begin
                        sm_we.state = (st_eff == TS_WAITING);
                    end
                    REQ_BLOCK: begin
                        sm_we.state = !r_idle;
                        sm_wr_state = TS_WAITING;
                    end
                    REQ_YIELD: begin
                        sm_we.state = run_ok;
                    end
                    REQ_TICK: begin
                        sm_we.state = run_ok;
                        sm_we.ticks = run_ok;
                    end
                    REQ_SETPRIO: begin
                        sm_we.prio = (st_eff != TS_FREE);
                    end
                    REQ_REMOVE: begin
                        sm_we.state = (st_eff != TS_FREE);
                        sm_wr_state = TS_FREE;
                    end
                    default: begin
                    end
                endcase
            end
            S_ENQ0: begin
                if (!lv_ne) begin
                    lv_head_we = 1'b1;
                    lv_ne_we   = 1'b1;
                    lk_nx_we   = 1'b1;
                    lk_pv_we   = 1'b1;
                end else begin
                    lk_rd_addr = lv_head;
                end
            end
            S_ENQ1: begin
                lk_nx_we   = 1'b1;
                lk_nx_data = lv_head;
                lk_pv_we   = 1'b1;
                lk_pv_data = lk_prev;
            end
            S_ENQ2: begin
                lk_nx_we   = 1'b1;
                lk_nx_addr = r_tail;
                lk_pv_we   = 1'b1;
                lk_pv_addr = lv_head;
            end
            S_DEQ1: begin
                if (lk_next == r_t) begin
                    lv_ne_we   = 1'b1;
                    lv_ne_data = 1'b0;
                end else begin
                    lk_nx_we     = 1'b1;
                    lk_nx_addr   = lk_prev;
                    lk_nx_data   = lk_next;
                    lk_pv_we     = 1'b1;
                    lk_pv_addr   = lk_next;
                    lk_pv_data   = lk_prev;
                    lv_head_we   = (lv_head == r_t);
                    lv_head_data = lk_next;
                end
            end
            S_SCH1: begin
                sm_wr_addr  = lv_head;
                sm_we.state = 1'b1;
                sm_wr_state = TS_RUNNING;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur      <= '0;
            r_idle     <= 1'b1;
            r_do_enq   <= 1'b0;
            r_do_sched <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req      <= i_req_type;
                        r_prio     <= in_prio;
                        r_slot_ok  <= in_ok;
                        r_addr     <= rd_addr;
                        r_old_cur  <= r_cur;
                        r_old_idle <= r_idle;
                        r_status   <= STAT_OK;
                        r_qs       <= '0;
                        r_qp       <= '0;
                        r_qc       <= '0;
                        r_do_enq   <= 1'b0;
                        r_do_sched <= 1'b0;
                        r_state    <= S_RDS;
                    end
                end
                S_RDS: begin
                    r_t     <= r_addr;
                    r_state <= S_DONE;
                    unique case (r_req)
                        REQ_CREATE: begin
                            if (!r_slot_ok || sm_state != TS_FREE) begin
                                r_status <= STAT_BAD_SLOT;
                            end else begin
                                r_lv    <= new_lv;
                                r_state <= S_ENQ0;
                            end
                        end
                        REQ_UNBLOCK: begin
                            if (st_eff == TS_FREE) begin
                                r_status <= STAT_BAD_SLOT;
                            end else if (st_eff != TS_WAITING) begin
                                r_status <= STAT_BAD_STATE;
                            end else begin
                                r_lv    <= rd_lv;
                                r_state <= S_ENQ0;
                            end
                        end
                        REQ_BLOCK: begin
                            if (r_idle) begin
                                r_status <= STAT_BAD_STATE;
                            end else begin
                                r_state <= S_SCH0;
                            end
                        end
                        REQ_YIELD, REQ_TICK: begin
                            if (run_ok) begin
                                r_lv       <= rd_lv;
                                r_do_sched <= 1'b1;
                                r_state    <= S_ENQ0;
                            end else begin
                                r_state <= S_SCH0;
                            end
                        end
                        REQ_SETPRIO: begin
                            if (st_eff == TS_FREE) begin
                                r_status <= STAT_BAD_SLOT;
                            end else if (st_eff == TS_READY) begin
                                r_lv     <= rd_lv;
                                r_new_lv <= new_lv;
                                r_do_enq <= 1'b1;
                                r_state  <= S_DEQ0;
                            end
                        end
                        REQ_REMOVE: begin
                            if (st_eff == TS_FREE) begin
                                r_status <= STAT_BAD_SLOT;
                            end else if (st_eff == TS_READY) begin
                                r_lv       <= rd_lv;
                                r_do_sched <= need_sched;
                                r_state    <= S_DEQ0;
                            end else if (need_sched) begin
                                r_state <= S_SCH0;
                            end
                        end
                        default: begin
                            if (st_eff == TS_FREE) begin
                                r_status <= STAT_BAD_SLOT;
                            end else begin
                                r_qs <= st_eff;
                                r_qp <= sm_prio;
                                r_qc <= sm_ticks;
                            end
                        end
                    endcase
                end
                S_ENQ0: begin
                    if (lv_ne) begin
                        r_state <= S_ENQ1;
                    end else begin
                        r_do_sched <= 1'b0;
                        r_state    <= r_do_sched ? S_SCH0 : S_DONE;
                    end
                end
                S_ENQ1: begin
                    r_tail  <= lk_prev;
                    r_state <= S_ENQ2;
                end
                S_ENQ2: begin
                    r_do_sched <= 1'b0;
                    r_state    <= r_do_sched ? S_SCH0 : S_DONE;
                end
                S_DEQ0: begin
                    r_state <= S_DEQ1;
                end
                S_DEQ1: begin
                    priority if (r_do_enq) begin
                        r_do_enq <= 1'b0;
                        r_lv     <= r_new_lv;
                        r_state  <= S_ENQ0;
                    end else if (r_do_sched) begin
                        r_do_sched <= 1'b0;
                        r_state    <= S_SCH0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCH0: begin
                    if (lv_any) begin
                        r_lv    <= lv_top;
                        r_state <= S_SCH1;
                    end else begin
                        r_idle  <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_SCH1: begin
                    r_t     <= lv_head;
                    r_cur   <= lv_head;
                    r_idle  <= 1'b0;
                    r_state <= S_DEQ0;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_slot   <= r_idle ? 6'd0 : cur_ext[5:0];
            r_o_idle   <= r_idle;
            r_o_sw     <= (r_old_idle != r_idle) || (!r_idle && r_old_cur != r_cur);
            r_o_status <= r_status;
            r_o_qs     <= r_qs;
            r_o_qp     <= r_qp;
            r_o_qc     <= r_qc;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_running_slot   = r_o_slot;
    assign o_running_idle   = r_o_idle;
    assign o_switched       = r_o_sw;
    assign o_result_status  = r_o_status;
    assign o_query_state    = r_o_qs;
    assign o_query_priority = r_o_qp;
    assign o_query_cpu_time = r_o_qc;

    prr_slot_mem #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_state (sm_state),
        .o_rd_prio  (sm_prio),
        .o_rd_ticks (sm_ticks),
        .i_wr_addr  (sm_wr_addr),
        .i_we       (sm_we),
        .i_wr_state (sm_wr_state),
        .i_wr_prio  (sm_wr_prio),
        .i_wr_ticks (sm_wr_ticks)
    );

    prr_link_mem #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_link_mem (
        .i_clk     (i_clk),
        .i_rd_addr (lk_rd_addr),
        .o_rd_next (lk_next),
        .o_rd_prev (lk_prev),
        .i_nx_we   (lk_nx_we),
        .i_nx_addr (lk_nx_addr),
        .i_nx_data (lk_nx_data),
        .i_pv_we   (lk_pv_we),
        .i_pv_addr (lk_pv_addr),
        .i_pv_data (lk_pv_data)
    );

    prr_level_table #(
        .THREAD_SLOTS    (THREAD_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_level_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lv        (r_lv),
        .o_head      (lv_head),
        .o_nonempty  (lv_ne),
        .i_head_we   (lv_head_we),
        .i_head_data (lv_head_data),
        .i_ne_we     (lv_ne_we),
        .i_ne_data   (lv_ne_data),
        .o_any       (lv_any),
        .o_top_lv    (lv_top)
    );

endmodule

@@ dv/priority_round_robin_scheduler_core_tb.sv @@
// Testbench for priority_round_robin_scheduler_core: directed and random scheduler requests.
// A scoreboard class predicts each result word from its own copy of the ready queues.
// Depends on prr_pkg and the core RTL.
module priority_round_robin_scheduler_core_tb import prr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  slot;
        logic        idle;
        logic        sw;
        logic [1:0]  status;
        logic [1:0]  qstate;
        logic [2:0]  qprio;
        logic [31:0] qticks;
    } t_sched_word;

    class sched_scoreboard;
        logic [5:0]  nxt [64];
        logic [5:0]  prv [64];
        logic [2:0]  prio [64];
        logic [1:0]  state [64];
        logic [31:0] ticks [64];
        logic [5:0]  head [8];
        logic [7:0]  busy;
        logic [5:0]  cur;
        logic        on_idle;
        t_sched_word pending[$];
        int          errors;

        function new();
            foreach (state[i]) state[i] = TS_FREE;
            busy    = '0;
            cur     = '0;
            on_idle = 1'b1;
            errors  = 0;
        endfunction

        function void link_tail(logic [5:0] t);
            logic [5:0] h;
            logic [5:0] tl;
            if (!busy[prio[t]]) begin
                head[prio[t]] = t;
                nxt[t] = t;
                prv[t] = t;
                busy[prio[t]] = 1'b1;
            end else begin
                h  = head[prio[t]];
                tl = prv[h];
                prv[t]  = tl;
                nxt[t]  = h;
                nxt[tl] = t;
                prv[h]  = t;
            end
            state[t] = TS_READY;
        endfunction

        function void unlink(logic [5:0] t);
            if (nxt[t] == t) begin
                busy[prio[t]] = 1'b0;
            end else begin
                nxt[prv[t]] = nxt[t];
                prv[nxt[t]] = prv[t];
                if (head[prio[t]] == t) head[prio[t]] = nxt[t];
            end
        endfunction

        function void pick_next();
            logic [5:0] t;
            for (int lv = 7; lv >= 0; lv--) begin
                if (busy[lv]) begin
                    t = head[lv];
                    unlink(t);
                    state[t] = TS_RUNNING;
                    cur      = t;
                    on_idle  = 1'b0;
                    return;
                end
            end
            on_idle = 1'b1;
        endfunction

        function void rotate();
            if (!on_idle && state[cur] == TS_RUNNING) link_tail(cur);
            pick_next();
        endfunction

        function void note(logic [2:0] req, logic [5:0] s, logic [2:0] p);
            t_sched_word w;
            logic        was_idle;
            logic [5:0]  was_cur;
            logic [1:0]  st;
            was_idle = on_idle;
            was_cur  = cur;
            st       = state[s];
            w        = '0;
            case (req)
                REQ_CREATE: begin
                    if (st != TS_FREE) w.status = STAT_BAD_SLOT;
                    else begin
                        prio[s]  = p;
                        ticks[s] = '0;
                        link_tail(s);
                    end
                end
                REQ_UNBLOCK: begin
                    if (st == TS_FREE) w.status = STAT_BAD_SLOT;
                    else if (st != TS_WAITING) w.status = STAT_BAD_STATE;
                    else link_tail(s);
                end
                REQ_BLOCK: begin
                    if (on_idle) w.status = STAT_BAD_STATE;
                    else begin
                        state[cur] = TS_WAITING;
                        pick_next();
                    end
                end
                REQ_YIELD: rotate();
                REQ_TICK: begin
                    if (!on_idle && state[cur] == TS_RUNNING) ticks[cur] = ticks[cur] + 1;
                    rotate();
                end
                REQ_SETPRIO: begin
                    if (st == TS_FREE) w.status = STAT_BAD_SLOT;
                    else if (st == TS_READY) begin
                        unlink(s);
                        prio[s] = p;
                        link_tail(s);
                    end else prio[s] = p;
                end
                REQ_REMOVE: begin
                    if (st == TS_FREE) w.status = STAT_BAD_SLOT;
                    else begin
                        if (st == TS_READY) unlink(s);
                        state[s] = TS_FREE;
                        if (!on_idle && cur == s) pick_next();
                    end
                end
                default: begin
                    if (st == TS_FREE) w.status = STAT_BAD_SLOT;
                    else begin
                        w.qstate = st;
                        w.qprio  = prio[s];
                        w.qticks = ticks[s];
                    end
                end
            endcase
            w.slot = on_idle ? 6'd0 : cur;
            w.idle = on_idle;
            w.sw   = (was_idle != on_idle) || (!on_idle && was_cur != cur);
            pending.push_back(w);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check(t_sched_word got);
            t_sched_word want;
            if (pending.size() == 0) begin
                report("unexpected word", 32'(got.slot), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.slot != want.slot)
                report("running_slot", 32'(got.slot), 32'(want.slot));
            if (got.idle != want.idle)
                report("running_idle", 32'(got.idle), 32'(want.idle));
            if (got.sw != want.sw)
                report("switched", 32'(got.sw), 32'(want.sw));
            if (got.status != want.status)
                report("result_status", 32'(got.status), 32'(want.status));
            if (got.qstate != want.qstate)
                report("query_state", 32'(got.qstate), 32'(want.qstate));
            if (got.qprio != want.qprio)
                report("query_priority", 32'(got.qprio), 32'(want.qprio));
            if (got.qticks != want.qticks) report("query_cpu_time", got.qticks, want.qticks);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [5:0]  i_thread_slot;
    logic [2:0]  i_priority_req;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [5:0]  o_running_slot;
    logic        o_running_idle;
    logic        o_switched;
    logic [1:0]  o_result_status;
    logic [1:0]  o_query_state;
    logic [2:0]  o_query_priority;
    logic [31:0] o_query_cpu_time;

    sched_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    priority_round_robin_scheduler_core u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL priority_round_robin_scheduler_core");
        $finish;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check({o_running_slot, o_running_idle, o_switched, o_result_status,
                          o_query_state, o_query_priority, o_query_cpu_time});
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task send_word(logic [2:0] req, logic [5:0] s, logic [2:0] p);
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_thread_slot  <= s;
        i_priority_req <= p;
        do @(posedge i_clk); while (o_in_stall);
        sb.note(req, s, p);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    task send_random();
        int          r;
        logic [2:0]  req;
        logic [5:0]  s;
        r = $urandom_range(99);
        if (r < 22)      req = REQ_CREATE;
        else if (r < 34) req = REQ_UNBLOCK;
        else if (r < 45) req = REQ_BLOCK;
        else if (r < 56) req = REQ_YIELD;
        else if (r < 70) req = REQ_TICK;
        else if (r < 80) req = REQ_SETPRIO;
        else if (r < 89) req = REQ_REMOVE;
        else             req = REQ_QUERY;
        s = ($urandom_range(9) < 8) ? 6'($urandom_range(11)) : 6'($urandom_range(63));
        send_word(req, s, 3'($urandom_range(7)));
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_req_type     <= REQ_QUERY;
        i_thread_slot  <= '0;
        i_priority_req <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(REQ_BLOCK, 6'd0, 3'd0);
        send_word(REQ_QUERY, 6'd5, 3'd0);
        send_word(REQ_CREATE, 6'd0, 3'd0);
        send_word(REQ_CREATE, 6'd63, 3'd7);
        send_word(REQ_CREATE, 6'd63, 3'd2);
        send_word(REQ_CREATE, 6'd42, 3'd5);
        send_word(REQ_QUERY, 6'd63, 3'd0);
        send_word(REQ_TICK, 6'd0, 3'd0);
        send_word(REQ_TICK, 6'd0, 3'd0);
        send_word(REQ_QUERY, 6'd63, 3'd0);
        send_word(REQ_BLOCK, 6'd0, 3'd0);
        send_word(REQ_UNBLOCK, 6'd0, 3'd0);
        send_word(REQ_UNBLOCK, 6'd63, 3'd0);
        send_word(REQ_UNBLOCK, 6'd21, 3'd0);
        send_word(REQ_SETPRIO, 6'd0, 3'd7);
        send_word(REQ_SETPRIO, 6'd21, 3'd3);
        send_word(REQ_SETPRIO, 6'd42, 3'd1);
        send_word(REQ_YIELD, 6'd0, 3'd0);
        send_word(REQ_QUERY, 6'd0, 3'd0);
        send_word(REQ_REMOVE, 6'd0, 3'd0);
        send_word(REQ_REMOVE, 6'd21, 3'd0);
        send_word(REQ_REMOVE, 6'd63, 3'd0);
        send_word(REQ_REMOVE, 6'd42, 3'd0);
        send_word(REQ_YIELD, 6'd0, 3'd0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 6 : 0;
            recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 6 : 0;
            for (int n = 0; n < 460; n++) begin
                if (ph == 0 && n == 100) hold_cycles = 300;
                send_random();
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS priority_round_robin_scheduler_core");
        end else begin
            $display("FAIL priority_round_robin_scheduler_core");
        end
        $finish;
    end
endmodule
